@@ hw/rtl/psfa_pkg.sv @@
// shared types and constants of the particle sensor frame averager
`default_nettype none

package psfa_pkg;

    // reading and result widths
    localparam int PM_W         = 16;
    localparam int MEAN_W       = 20;
    localparam int SAMPLES_W    = 5;
    localparam int NUM_READINGS = 3;
    localparam int MEAN_MAX     = 20'hFFFFF;

    // frame layout
    localparam int START_BYTE        = 8'h42;
    localparam int FRAME_LEN         = 32;
    localparam int POS_W             = 5;
    localparam int SUM_LEN           = 30;
    localparam int FIRST_READING_POS = 10;
    localparam int LAST_READING_POS  = 15;
    localparam int POS_LAST          = FRAME_LEN - 1;

    // one parsed frame handed from the front to the back
    typedef struct packed {
        logic [NUM_READINGS-1:0][PM_W-1:0] pm;
        logic                              good;
    } psfa_frame_t;

endpackage

`default_nettype wire

@@ hw/rtl/psfa_front.sv @@
// byte parser: hunts for the start byte, collects readings and checks the sum
`default_nettype none

module psfa_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            rx_byte,
    input  logic                  rx_valid,
    output logic                  rx_ready,
    output psfa_pkg::psfa_frame_t frame,
    output logic                  frame_valid,
    input  logic                  frame_ready
);
    import psfa_pkg::*;

    logic [POS_W-1:0]    pos_reg;
    logic [15:0]         sum_reg;
    logic [7:0]          chk_high_reg;
    logic [PM_W-1:0]     readings_reg [NUM_READINGS];
    logic                byte_take;
    logic                in_readings;
    logic [1:0]          reading_idx;
    logic [POS_W-1:0]    reading_off;

    // a word is taken only when the queue can hold a finished frame
    assign rx_ready  = frame_ready;
    assign byte_take = rx_valid && rx_ready;

    // readings occupy bytes 10..15, two bytes per reading
    assign in_readings = (pos_reg >= POS_W'(FIRST_READING_POS)) &&
                         (pos_reg <= POS_W'(LAST_READING_POS));
    assign reading_off = pos_reg - POS_W'(FIRST_READING_POS);
    assign reading_idx = reading_off[2:1];

    // frame record offered on the last byte
    assign frame_valid = rx_valid && (pos_reg == POS_W'(POS_LAST));
    assign frame.pm[0] = readings_reg[0];
    assign frame.pm[1] = readings_reg[1];
    assign frame.pm[2] = readings_reg[2];
    assign frame.good  = ({chk_high_reg, rx_byte} == sum_reg);

    // position counter and running byte sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            chk_high_reg <= '0;
        end
        else if (byte_take)
        begin
            if (pos_reg == '0)
            begin
                if (rx_byte == 8'(START_BYTE))
                begin
                    sum_reg <= 16'(rx_byte);
                    pos_reg <= POS_W'(1);
                end
            end
            else
            begin
                if (pos_reg < POS_W'(SUM_LEN))
                    sum_reg <= sum_reg + 16'(rx_byte);
                if (pos_reg == POS_W'(SUM_LEN))
                    chk_high_reg <= rx_byte;
                if (pos_reg == POS_W'(POS_LAST))
                    pos_reg <= '0;
                else
                    pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // big-endian reading capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_READINGS; i++)
                readings_reg[i] <= '0;
        end
        else if (byte_take && in_readings)
        begin
            if (!pos_reg[0])
                readings_reg[reading_idx][15:8] <= rx_byte;
            else
                readings_reg[reading_idx][7:0] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/psfa_queue.sv @@
// two-entry frame queue between the parser and the averager
`default_nettype none

module psfa_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psfa_pkg::psfa_frame_t in_frame,
    input  logic                  in_valid,
    output logic                  in_ready,
    output psfa_pkg::psfa_frame_t out_frame,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import psfa_pkg::*;

    psfa_frame_t entries_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        push;
    logic        pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_frame = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= in_frame;
    end

endmodule

`default_nettype wire

@@ hw/rtl/psfa_back.sv @@
// averager: history ring, running totals, serial rounding divider, result register
`default_nettype none

module psfa_back #(
    parameter int WINDOW    = 25,
    parameter int FRAC_BITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psfa_pkg::psfa_frame_t             frame,
    input  logic                              frame_valid,
    output logic                              frame_ready,
    output logic [psfa_pkg::PM_W-1:0]         pm1_now,
    output logic [psfa_pkg::PM_W-1:0]         pm2_5_now,
    output logic [psfa_pkg::PM_W-1:0]         pm10_now,
    output logic [psfa_pkg::MEAN_W-1:0]       pm1_mean,
    output logic [psfa_pkg::MEAN_W-1:0]       pm2_5_mean,
    output logic [psfa_pkg::MEAN_W-1:0]       pm10_mean,
    output logic [psfa_pkg::SAMPLES_W-1:0]    samples_in_window,
    output logic                              frame_status,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import psfa_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOT_W  = PM_W + CNT_W;
    localparam int NUM_W  = TOT_W + FRAC_BITS + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ACCUM,
        ST_LOAD,
        ST_DIVIDE,
        ST_SAVE,
        ST_FINISH
    } state_t;

    state_t                            state_reg;
    psfa_frame_t                       cur_reg;
    logic [SLOT_W-1:0]                 slot_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [TOT_W-1:0]                  totals_reg [NUM_READINGS];
    logic [NUM_W-1:0]                  quo_reg    [NUM_READINGS];
    logic [CNT_W-1:0]                  rem_reg    [NUM_READINGS];
    logic [MEAN_W-1:0]                 means_reg  [NUM_READINGS];
    logic [STEP_W-1:0]                 step_reg;
    logic [NUM_READINGS-1:0][PM_W-1:0] ring_mem   [WINDOW];
    logic [NUM_READINGS-1:0][PM_W-1:0] ring_rd_reg;

    logic                              full;
    logic                              out_load;
    logic [TOT_W-1:0]                  tot_nx     [NUM_READINGS];
    logic [CNT_W:0]                    rem_sh     [NUM_READINGS];
    logic [CNT_W-1:0]                  rem_nx     [NUM_READINGS];
    logic [NUM_W-1:0]                  quo_nx     [NUM_READINGS];
    logic [MEAN_W-1:0]                 mean_sat   [NUM_READINGS];
    logic [CNT_W:0]                    den_ext;

    assign frame_ready = (state_reg == ST_IDLE);
    assign full        = (count_reg == CNT_W'(WINDOW));
    assign den_ext     = {1'b0, count_reg};

    // result register loads when the finished word has room
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid || out_ready);

    // total update: oldest entry leaves once the window is full
    always_comb
    begin
        for (int k = 0; k < NUM_READINGS; k++)
        begin
            tot_nx[k] = totals_reg[k] + TOT_W'(cur_reg.pm[k]);
            if (full)
                tot_nx[k] = tot_nx[k] - TOT_W'(ring_rd_reg[k]);
        end
    end

    // one restoring divide step per lane
    always_comb
    begin
        for (int k = 0; k < NUM_READINGS; k++)
        begin
            rem_sh[k] = {rem_reg[k], quo_reg[k][NUM_W-1]};
            if (rem_sh[k] >= den_ext)
            begin
                rem_nx[k] = CNT_W'(rem_sh[k] - den_ext);
                quo_nx[k] = {quo_reg[k][NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_nx[k] = CNT_W'(rem_sh[k]);
                quo_nx[k] = {quo_reg[k][NUM_W-2:0], 1'b0};
            end
        end
    end

    // clamp quotient to the mean field
    always_comb
    begin
        for (int k = 0; k < NUM_READINGS; k++)
        begin
            if (32'(quo_reg[k]) > 32'(MEAN_MAX))
                mean_sat[k] = MEAN_W'(MEAN_MAX);
            else
                mean_sat[k] = MEAN_W'(quo_reg[k]);
        end
    end

    // history ring, registered read at the write slot
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACCUM)
            ring_mem[slot_reg] <= cur_reg.pm;
        ring_rd_reg <= ring_mem[slot_reg];
    end

    // sequencer with result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cur_reg           <= '0;
            slot_reg          <= '0;
            count_reg         <= '0;
            step_reg          <= '0;
            out_valid         <= 1'b0;
            pm1_now           <= '0;
            pm2_5_now         <= '0;
            pm10_now          <= '0;
            pm1_mean          <= '0;
            pm2_5_mean        <= '0;
            pm10_mean         <= '0;
            samples_in_window <= '0;
            frame_status      <= 1'b0;
            for (int k = 0; k < NUM_READINGS; k++)
            begin
                totals_reg[k] <= '0;
                quo_reg[k]    <= '0;
                rem_reg[k]    <= '0;
                means_reg[k]  <= '0;
            end
        end
        else
        begin
            if (out_load)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (frame_valid)
                    begin
                        cur_reg   <= frame;
                        state_reg <= frame.good ? ST_FETCH : ST_FINISH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    for (int k = 0; k < NUM_READINGS; k++)
                        totals_reg[k] <= tot_nx[k];
                    if (!full)
                        count_reg <= count_reg + CNT_W'(1);
                    if (slot_reg == SLOT_W'(WINDOW - 1))
                        slot_reg <= '0;
                    else
                        slot_reg <= slot_reg + SLOT_W'(1);
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    // dividend is total scaled plus half the count for rounding
                    for (int k = 0; k < NUM_READINGS; k++)
                    begin
                        quo_reg[k] <= (NUM_W'(totals_reg[k]) << FRAC_BITS) +
                                      NUM_W'(count_reg >> 1);
                        rem_reg[k] <= '0;
                    end
                    step_reg  <= '0;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    for (int k = 0; k < NUM_READINGS; k++)
                    begin
                        quo_reg[k] <= quo_nx[k];
                        rem_reg[k] <= rem_nx[k];
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(NUM_W - 1))
                        state_reg <= ST_SAVE;
                end
                ST_SAVE:
                begin
                    for (int k = 0; k < NUM_READINGS; k++)
                        means_reg[k] <= mean_sat[k];
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        pm1_now           <= cur_reg.good ? cur_reg.pm[0] : '0;
                        pm2_5_now         <= cur_reg.good ? cur_reg.pm[1] : '0;
                        pm10_now          <= cur_reg.good ? cur_reg.pm[2] : '0;
                        pm1_mean          <= means_reg[0];
                        pm2_5_mean        <= means_reg[1];
                        pm10_mean         <= means_reg[2];
                        samples_in_window <= SAMPLES_W'(count_reg);
                        frame_status      <= ~cur_reg.good;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // frame count never passes the window
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW))
        else $error("frame count beyond window");

    // write slot stays inside the ring
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot outside ring");

    // divider never runs with a zero divisor
    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (count_reg != '0))
        else $error("divide by zero count");

    // a mismatch word carries no readings
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_status) |->
            (pm1_now == '0 && pm2_5_now == '0 && pm10_now == '0))
        else $error("mismatch word with readings");

    // a good frame only reaches the output through the divider
    a_good_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAVE) |-> $past(state_reg == ST_DIVIDE))
        else $error("means saved without divide");

endmodule

`default_nettype wire

@@ hw/rtl/particle_sensor_frame_averager.sv @@
// Particle sensor frame averager: parses 32-byte sensor frames and averages readings.
//
// Input channel rx_byte / rx_valid / rx_ready takes one received byte per word.
// Bytes are dropped until a 0x42 start byte; then 32 bytes form a frame whose
// checksum is compared against the 16-bit sum of bytes 0..29.
// Output channel out_valid / out_ready gives one word per completed frame:
// the three readings, their window averages with FRAC_BITS fraction bits
// (rounded to nearest, clamped to 20 bits), the frame count and a status bit.
// Bytes are taken at one per cycle while rx_ready is high. A good frame passes
// through the queue and the averager states fetch, accumulate, load, bit-serial
// divide, save and finish before out_valid rises; the dividend is NUM_W = 16 +
// clog2(WINDOW+1) + FRAC_BITS + 1 bits wide. A mismatch frame skips the divider.
// A two-frame queue sits between the byte parser and the averager, so the
// parser keeps taking bytes while a result waits; rx_ready drops only when
// both queue entries hold frames the averager has not yet taken.
// Reset clears the parser, the frame count, totals and means; the history
// ring is not cleared, its entries are read only after being written.
`default_nettype none

module particle_sensor_frame_averager #(
    parameter int WINDOW    = 25,
    parameter int FRAC_BITS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [7:0]                     rx_byte,
    input  logic                           rx_valid,
    output logic                           rx_ready,
    output logic [psfa_pkg::PM_W-1:0]      pm1_now,
    output logic [psfa_pkg::PM_W-1:0]      pm2_5_now,
    output logic [psfa_pkg::PM_W-1:0]      pm10_now,
    output logic [psfa_pkg::MEAN_W-1:0]    pm1_mean,
    output logic [psfa_pkg::MEAN_W-1:0]    pm2_5_mean,
    output logic [psfa_pkg::MEAN_W-1:0]    pm10_mean,
    output logic [psfa_pkg::SAMPLES_W-1:0] samples_in_window,
    output logic                           frame_status,
    output logic                           out_valid,
    input  logic                           out_ready
);
    import psfa_pkg::*;

    psfa_frame_t front_frame;
    logic        front_valid;
    logic        front_ready;
    psfa_frame_t back_frame;
    logic        back_valid;
    logic        back_ready;

    // byte parser
    psfa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .frame       (front_frame),
        .frame_valid (front_valid),
        .frame_ready (front_ready)
    );

    // frame queue
    psfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_frame  (front_frame),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_frame (back_frame),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    // averager
    psfa_back #(
        .WINDOW    (WINDOW),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame             (back_frame),
        .frame_valid       (back_valid),
        .frame_ready       (back_ready),
        .pm1_now           (pm1_now),
        .pm2_5_now         (pm2_5_now),
        .pm10_now          (pm10_now),
        .pm1_mean          (pm1_mean),
        .pm2_5_mean        (pm2_5_mean),
        .pm10_mean         (pm10_mean),
        .samples_in_window (samples_in_window),
        .frame_status      (frame_status),
        .out_valid         (out_valid),
        .out_ready         (out_ready)
    );

endmodule

`default_nettype wire
